### rtl/fpa_pkg.sv
package fpa_pkg;

    localparam int unsigned FPA_FRAC_BITS = 8;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned DIV_STEPS     = WORD_W;

    localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_SUB   = 4'd1,
        MODE_MUL   = 4'd2,
        MODE_DIV   = 4'd3,
        MODE_LT    = 4'd4,
        MODE_LE    = 4'd5,
        MODE_GT    = 4'd6,
        MODE_GE    = 4'd7,
        MODE_NE    = 4'd8,
        MODE_EQ    = 4'd9,
        MODE_MIN   = 4'd10,
        MODE_MAX   = 4'd11,
        MODE_INC   = 4'd12,
        MODE_DEC   = 4'd13,
        MODE_TOINT = 4'd14
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVF     = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        mode_t             mode;
        logic              neg;
        logic [WORD_W-1:0] mb;
        logic [WORD_W-1:0] r;
        logic              cmp;
        status_t           status;
        logic              div_ovf;
        logic [WORD_W:0]   mag;
        logic              mag_big;
    } side_t;

endpackage

### rtl/fixed_point_alu.sv
// 36 register stages from input register to result register, 32 of them beside the 32-stage divider
// throughput: one transfer per cycle when not stalled, every mode runs through the same pipeline
// a stall at the result side holds every stage, nothing is dropped or repeated
// reset: synchronous active-low aresetn clears all stage valid bits
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FPA_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [3:0]               s_mode,
    input  logic signed [WORD_W-1:0] s_operand_a,
    input  logic signed [WORD_W-1:0] s_operand_b,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_result_value,
    output logic                     m_compare_true,
    output logic [1:0]               m_status
);

    localparam logic [2*WORD_W-1:0] HALF = (64'd1 << FRAC_BITS) >> 1;

    logic adv;

    // stage 1: input register
    logic                     v1_reg;
    mode_t                    mode1_reg;
    logic signed [WORD_W-1:0] a1_reg;
    logic signed [WORD_W-1:0] b1_reg;

    // stage 2
    side_t             s2_next, s2_reg;
    logic [WORD_W-1:0] ma, mb;
    logic [WORD_W:0]   sum_ab, dif_ab;
    logic [2*WORD_W-1:0] num;
    logic [WORD_W-1:0] ti_mag;
    logic [WORD_W-1:0] drem_reg, dlo_reg, dden_reg;
    logic [WORD_W-1:0] ma2_reg;

    // delay line alongside the divider
    side_t               dl_reg [DIV_STEPS];
    logic [2*WORD_W-1:0] prod_reg;
    logic [2*WORD_W-1:0] prod_rnd;

    logic [WORD_W-1:0] quo, rem;

    side_t           f1_next, f1_reg;
    logic [WORD_W:0] div_mag;

    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] out_r_next, out_r_reg;
    logic                     out_cmp_reg;
    status_t                  out_st_next, out_st_reg;
    mode_t                    out_mode_reg;
    logic [WORD_W:0]          neg_mag;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
        if (adv) begin
            mode1_reg <= mode_t'(s_mode);
            a1_reg    <= s_operand_a;
            b1_reg    <= s_operand_b;
        end
    end

    always_comb begin
        ma     = a1_reg[WORD_W-1] ? (~a1_reg + 1'b1) : a1_reg;
        mb     = b1_reg[WORD_W-1] ? (~b1_reg + 1'b1) : b1_reg;
        sum_ab = {a1_reg[WORD_W-1], a1_reg} + {b1_reg[WORD_W-1], b1_reg};
        dif_ab = {a1_reg[WORD_W-1], a1_reg} - {b1_reg[WORD_W-1], b1_reg};
        num    = {{WORD_W{1'b0}}, ma} << FRAC_BITS;
        ti_mag = ma >> FRAC_BITS;

        s2_next         = '0;
        s2_next.valid   = v1_reg;
        s2_next.mode    = mode1_reg;
        s2_next.neg     = a1_reg[WORD_W-1] ^ b1_reg[WORD_W-1];
        s2_next.mb      = mb;
        s2_next.status  = ST_OK;
        s2_next.div_ovf = num[2*WORD_W-1:WORD_W] >= mb;

        case (mode1_reg)
            MODE_ADD: begin
                s2_next.r = sum_ab[WORD_W-1:0];
                if (sum_ab[WORD_W] != sum_ab[WORD_W-1]) begin
                    s2_next.r      = sum_ab[WORD_W] ? SAT_MIN : SAT_MAX;
                    s2_next.status = ST_OVF;
                end
            end
            MODE_SUB: begin
                s2_next.r = dif_ab[WORD_W-1:0];
                if (dif_ab[WORD_W] != dif_ab[WORD_W-1]) begin
                    s2_next.r      = dif_ab[WORD_W] ? SAT_MIN : SAT_MAX;
                    s2_next.status = ST_OVF;
                end
            end
            MODE_DIV: begin
                if (b1_reg == '0) begin
                    s2_next.status = ST_DIVZERO;
                end
            end
            MODE_LT:  s2_next.cmp = a1_reg <  b1_reg;
            MODE_LE:  s2_next.cmp = a1_reg <= b1_reg;
            MODE_GT:  s2_next.cmp = a1_reg >  b1_reg;
            MODE_GE:  s2_next.cmp = a1_reg >= b1_reg;
            MODE_NE:  s2_next.cmp = a1_reg != b1_reg;
            MODE_EQ:  s2_next.cmp = a1_reg == b1_reg;
            MODE_MIN: s2_next.r = (a1_reg > b1_reg) ? b1_reg : a1_reg;
            MODE_MAX: s2_next.r = (a1_reg > b1_reg) ? a1_reg : b1_reg;
            MODE_INC: begin
                if (a1_reg == SAT_MAX) begin
                    s2_next.r      = SAT_MAX;
                    s2_next.status = ST_OVF;
                end else begin
                    s2_next.r = a1_reg + 1'b1;
                end
            end
            MODE_DEC: begin
                if (a1_reg == SAT_MIN) begin
                    s2_next.r      = SAT_MIN;
                    s2_next.status = ST_OVF;
                end else begin
                    s2_next.r = a1_reg - 1'b1;
                end
            end
            MODE_TOINT: s2_next.r = a1_reg[WORD_W-1] ? (~ti_mag + 1'b1) : ti_mag;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg.valid <= 1'b0;
        end else if (adv) begin
            s2_reg.valid <= s2_next.valid;
        end
        if (adv) begin
            s2_reg.mode    <= s2_next.mode;
            s2_reg.neg     <= s2_next.neg;
            s2_reg.mb      <= s2_next.mb;
            s2_reg.r       <= s2_next.r;
            s2_reg.cmp     <= s2_next.cmp;
            s2_reg.status  <= s2_next.status;
            s2_reg.div_ovf <= s2_next.div_ovf;
            s2_reg.mag     <= s2_next.mag;
            s2_reg.mag_big <= s2_next.mag_big;
            // high word already at or above the divisor means quotient overflow
            drem_reg <= s2_next.div_ovf ? '0 : num[2*WORD_W-1:WORD_W];
            dlo_reg  <= num[WORD_W-1:0];
            dden_reg <= mb;
            ma2_reg  <= ma;
        end
    end

    fpa_div_pipe u_div (
        .aclk    (aclk),
        .en      (adv),
        .rem_in  (drem_reg),
        .lo_in   (dlo_reg),
        .den_in  (dden_reg),
        .quo_out (quo),
        .rem_out (rem)
    );

    assign prod_rnd = (prod_reg + HALF) >> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STEPS; i++) begin
                dl_reg[i].valid <= 1'b0;
            end
        end else if (adv) begin
            dl_reg[0].valid <= s2_reg.valid;
            for (int i = 1; i < DIV_STEPS; i++) begin
                dl_reg[i].valid <= dl_reg[i-1].valid;
            end
        end
        if (adv) begin
            prod_reg <= {{WORD_W{1'b0}}, ma2_reg} * {{WORD_W{1'b0}}, s2_reg.mb};
            dl_reg[0].mode    <= s2_reg.mode;
            dl_reg[0].neg     <= s2_reg.neg;
            dl_reg[0].mb      <= s2_reg.mb;
            dl_reg[0].r       <= s2_reg.r;
            dl_reg[0].cmp     <= s2_reg.cmp;
            dl_reg[0].status  <= s2_reg.status;
            dl_reg[0].div_ovf <= s2_reg.div_ovf;
            dl_reg[0].mag     <= s2_reg.mag;
            dl_reg[0].mag_big <= s2_reg.mag_big;
            for (int i = 1; i < DIV_STEPS; i++) begin
                dl_reg[i].mode    <= dl_reg[i-1].mode;
                dl_reg[i].neg     <= dl_reg[i-1].neg;
                dl_reg[i].mb      <= dl_reg[i-1].mb;
                dl_reg[i].r       <= dl_reg[i-1].r;
                dl_reg[i].cmp     <= dl_reg[i-1].cmp;
                dl_reg[i].status  <= dl_reg[i-1].status;
                dl_reg[i].div_ovf <= dl_reg[i-1].div_ovf;
            end
            // rounded product joins the line one stage after the multiplier
            dl_reg[1].mag     <= prod_rnd[WORD_W:0];
            dl_reg[1].mag_big <= |prod_rnd[2*WORD_W-1:WORD_W+1];
            for (int i = 2; i < DIV_STEPS; i++) begin
                dl_reg[i].mag     <= dl_reg[i-1].mag;
                dl_reg[i].mag_big <= dl_reg[i-1].mag_big;
            end
        end
    end

    always_comb begin
        div_mag = {1'b0, quo} + {{WORD_W{1'b0}},
                  ({rem, 1'b0} >= {1'b0, dl_reg[DIV_STEPS-1].mb})};
        f1_next = dl_reg[DIV_STEPS-1];
        if (dl_reg[DIV_STEPS-1].mode == MODE_DIV) begin
            f1_next.mag     = div_mag;
            f1_next.mag_big = dl_reg[DIV_STEPS-1].div_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_reg.valid <= 1'b0;
        end else if (adv) begin
            f1_reg.valid <= f1_next.valid;
        end
        if (adv) begin
            f1_reg.mode    <= f1_next.mode;
            f1_reg.neg     <= f1_next.neg;
            f1_reg.mb      <= f1_next.mb;
            f1_reg.r       <= f1_next.r;
            f1_reg.cmp     <= f1_next.cmp;
            f1_reg.status  <= f1_next.status;
            f1_reg.div_ovf <= f1_next.div_ovf;
            f1_reg.mag     <= f1_next.mag;
            f1_reg.mag_big <= f1_next.mag_big;
        end
    end

    // sign and saturate the mul and div magnitudes
    always_comb begin
        neg_mag     = ~f1_reg.mag + 1'b1;
        out_r_next  = f1_reg.r;
        out_st_next = f1_reg.status;
        if ((f1_reg.mode == MODE_MUL || f1_reg.mode == MODE_DIV)
                && f1_reg.status != ST_DIVZERO) begin
            if (f1_reg.neg) begin
                if (f1_reg.mag_big || f1_reg.mag > {1'b0, SAT_MIN}) begin
                    out_r_next  = SAT_MIN;
                    out_st_next = ST_OVF;
                end else begin
                    out_r_next = neg_mag[WORD_W-1:0];
                end
            end else begin
                if (f1_reg.mag_big || f1_reg.mag > {1'b0, SAT_MAX}) begin
                    out_r_next  = SAT_MAX;
                    out_st_next = ST_OVF;
                end else begin
                    out_r_next = f1_reg.mag[WORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= f1_reg.valid;
        end
        if (adv) begin
            out_r_reg    <= out_r_next;
            out_cmp_reg  <= f1_reg.cmp;
            out_st_reg   <= out_st_next;
            out_mode_reg <= f1_reg.mode;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_r_reg;
    assign m_compare_true = out_cmp_reg;
    assign m_status       = out_st_reg;

`ifndef SYNTHESIS
    a_divzero_only_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && out_st_reg == ST_DIVZERO) |-> (out_mode_reg == MODE_DIV))
        else $error("divide by zero status outside divide mode");

    a_cmp_only_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && out_cmp_reg) |-> (out_mode_reg == MODE_LT || out_mode_reg == MODE_LE
            || out_mode_reg == MODE_GT || out_mode_reg == MODE_GE
            || out_mode_reg == MODE_NE || out_mode_reg == MODE_EQ))
        else $error("compare flag set outside compare modes");

    a_divzero_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && out_st_reg == ST_DIVZERO) |-> (out_r_reg == '0))
        else $error("divide by zero result not cleared");

    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && out_st_reg == ST_OVF) |-> (out_r_reg == SAT_MAX || out_r_reg == SAT_MIN))
        else $error("overflow status without saturated result");
`endif

endmodule

### rtl/fpa_div_pipe.sv
module fpa_div_pipe
    import fpa_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [WORD_W-1:0] rem_in,
    input  logic [WORD_W-1:0] lo_in,
    input  logic [WORD_W-1:0] den_in,
    output logic [WORD_W-1:0] quo_out,
    output logic [WORD_W-1:0] rem_out
);

    // one quotient bit per stage, quotient shifts into the low word
    logic [WORD_W-1:0] rem_reg  [DIV_STEPS];
    logic [WORD_W-1:0] lo_reg   [DIV_STEPS];
    logic [WORD_W-1:0] den_reg  [DIV_STEPS];
    logic [WORD_W-1:0] rem_next [DIV_STEPS];
    logic [WORD_W-1:0] lo_next  [DIV_STEPS];
    logic [WORD_W-1:0] den_next [DIV_STEPS];
    logic [WORD_W:0]   trial    [DIV_STEPS];
    logic [WORD_W:0]   diff     [DIV_STEPS];
    logic              ge       [DIV_STEPS];

    always_comb begin
        for (int i = 0; i < DIV_STEPS; i++) begin
            if (i == 0) begin
                trial[i]    = {rem_in, lo_in[WORD_W-1]};
                den_next[i] = den_in;
                lo_next[i]  = {lo_in[WORD_W-2:0], 1'b0};
            end else begin
                trial[i]    = {rem_reg[i-1], lo_reg[i-1][WORD_W-1]};
                den_next[i] = den_reg[i-1];
                lo_next[i]  = {lo_reg[i-1][WORD_W-2:0], 1'b0};
            end
            diff[i]       = trial[i] - {1'b0, den_next[i]};
            ge[i]         = trial[i] >= {1'b0, den_next[i]};
            lo_next[i][0] = ge[i];
            rem_next[i]   = ge[i] ? diff[i][WORD_W-1:0] : trial[i][WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STEPS; i++) begin
                rem_reg[i] <= rem_next[i];
                lo_reg[i]  <= lo_next[i];
                den_reg[i] <= den_next[i];
            end
        end
    end

    assign quo_out = lo_reg[DIV_STEPS-1];
    assign rem_out = rem_reg[DIV_STEPS-1];

endmodule
